// File: hw/rtl/text_console_line_ring_top_macros.svh
// Assertion helpers for the console ring top level.
// They use the clk and rst_n of the module that includes this file.
`ifndef TEXT_CONSOLE_LINE_RING_TOP_MACROS_SVH
`define TEXT_CONSOLE_LINE_RING_TOP_MACROS_SVH

// same-cycle implication
`define TCLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tclr_pkg.sv
`default_nettype none
package tclr_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 48;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COLI_W = $clog2(MAX_COLS);      // store column index
  localparam int COL_W  = $clog2(MAX_COLS + 1);  // cursor column, may equal cols
  localparam int ROW_W  = $clog2(MAX_ROWS);      // store row index
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);  // row count
  localparam int CMP_W  = ROW_W + 1;

  // fixed field widths
  localparam int CHAR_W       = 8;
  localparam int OP_W         = 2;
  localparam int IN_ROW_W     = 6;
  localparam int IN_COL_W     = 7;
  localparam int OUT_COL_W    = 8;
  localparam int OUT_ROW_W    = 6;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int COLS_CFG_W   = 8;
  localparam int ROWS_CFG_W   = 6;

  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd128;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd48;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;

  localparam logic [CHAR_W-1:0] CODE_BS     = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NL     = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_LOWEST = 8'd6;
  localparam logic [CHAR_W-1:0] CODE_SPACE  = 8'h20;

  localparam int TAB_SPACES = 4;
  localparam int TAB_CNT_W  = $clog2(TAB_SPACES);

  typedef struct packed {
    logic              go;
    logic [RCNT_W-1:0] val;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [ROW_W-1:0] res;
  } mod_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } ram_wr_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COLI_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tclr_char_ram.sv
`default_nettype none
module tclr_char_ram
  import tclr_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_wr_t           wr,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/tclr_mod_unit.sv
`default_nettype none
module tclr_mod_unit
  import tclr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mod_req_t          req,
  input  wire logic [RCNT_W-1:0] modulus,
  output mod_rsp_t               rsp
);

  logic              busy_r;
  logic [RCNT_W-1:0] rem_r;
  logic              below;

  assign below = (rem_r < modulus);

  // one subtract per cycle until the remainder drops below the row count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.go) begin
      busy_r <= 1'b1;
      rem_r  <= req.val;
    end else if (busy_r) begin
      if (below) begin
        busy_r <= 1'b0;
      end else begin
        rem_r <= rem_r - modulus;
      end
    end
  end

  assign rsp.done = busy_r && below;
  assign rsp.res  = ROW_W'(rem_r);

endmodule
`default_nettype wire

// File: hw/rtl/text_console_line_ring_top.sv
// Console ring top level: one word in, one word out; the next word is taken the
// cycle after the result is registered. Reads and clears go straight to the
// store read; wraps, newlines and the tab loop also wait on the modulo unit,
// which subtracts the row count until the remainder drops below it.
// Sync reset clears pointers and config; then input stalls while the character
// store is zeroed one cell per cycle.
`default_nettype none
`include "text_console_line_ring_top_macros.svh"
module text_console_line_ring_top
  import tclr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic [CHAR_W-1:0]    in_ch,
  input  wire logic [IN_ROW_W-1:0]  in_read_row,
  input  wire logic [IN_COL_W-1:0]  in_read_col,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_COL_W-1:0]      out_cursor_col,
  output logic [OUT_ROW_W-1:0]      out_cursor_row,
  output logic [OUT_ROW_W-1:0]      out_top_row,
  output logic                      out_scrolling,
  output logic [CHAR_W-1:0]         out_cell_char
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_WRAP_TOP, ST_CHAR, ST_TAB, ST_TAB_PUT,
    ST_MOD_WAIT, ST_FINISH, ST_READ, ST_RDATA
  } state_t;

  state_t state_r;
  state_t ret_r;

  logic [COLS_CFG_W-1:0] cols_cfg_r;
  logic [ROWS_CFG_W-1:0] rows_cfg_r;

  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    line_r;
  logic [ROW_W-1:0]    top_r;
  logic                flag_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [IN_ROW_W-1:0] rrow_r;
  logic [IN_COL_W-1:0] rcol_r;
  logic [TAB_CNT_W-1:0] tab_cnt_r;
  logic                mod_to_top_r;

  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  mod_req_t mod_req_r;
  mod_rsp_t mod_rsp;
  ram_wr_t  ram_wr_r;
  ram_wr_t  ram_wr;
  logic [CHAR_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              rd_oob;

  logic                 out_valid_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [OUT_ROW_W-1:0] out_top_r;
  logic                 out_scr_r;
  logic [CHAR_W-1:0]    out_cell_r;

  logic [COL_W-1:0]  cols_eff;
  logic [RCNT_W-1:0] rows_eff;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              col_wrap;
  logic [CMP_W-1:0]  line_p1;
  logic [CMP_W-1:0]  top_p1;
  logic              line_p1_wraps;
  logic              top_move;
  logic [ADDR_W-1:0] cur_addr;

  // effective geometry: zero acts as one, oversize clamps to the store
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = COL_W'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_cfg_r);
    end
  end

  assign last_col      = cols_eff - COL_W'(1);
  assign last_row      = ROW_W'(rows_eff - RCNT_W'(1));
  assign col_wrap      = (col_r >= cols_eff);
  assign line_p1       = CMP_W'(line_r) + CMP_W'(1);
  assign top_p1        = CMP_W'(top_r) + CMP_W'(1);
  assign line_p1_wraps = (line_p1 >= CMP_W'(rows_eff));
  assign cur_addr      = cell_addr(line_r, col_r[COLI_W-1:0]);

  // once scrolling has begun, top follows the cursor when it lands on or next
  // to it, or on the last row while top is still at zero
  assign top_move = flag_r &&
                    ((line_r == top_r) || (CMP_W'(line_r) == top_p1) ||
                     (CMP_W'(top_r) == line_p1) ||
                     ((line_r == last_row) && (top_r == '0)));

  assign in_stall = (state_r != ST_IDLE) || clr_busy_r;

  assign rd_oob = (32'(rrow_r) >= MAX_ROWS) || (32'(rcol_r) >= MAX_COLS);
  assign raddr  = cell_addr(rrow_r[ROW_W-1:0], rcol_r[COLI_W-1:0]);

  always_comb begin
    if (clr_busy_r) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = clr_cnt_r;
      ram_wr.data = '0;
    end else begin
      ram_wr = ram_wr_r;
    end
  end

  tclr_char_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  tclr_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req_r),
    .modulus (rows_eff),
    .rsp     (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLS_RESET;
      rows_cfg_r <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_cfg_r <= cfg_wdata;
        CFG_ROWS: rows_cfg_r <= cfg_wdata[ROWS_CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      col_r        <= '0;
      line_r       <= '0;
      top_r        <= '0;
      flag_r       <= 1'b0;
      tab_cnt_r    <= '0;
      mod_to_top_r <= 1'b0;
      mod_req_r    <= '0;
      ram_wr_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      mod_req_r.go <= 1'b0;
      ram_wr_r.en  <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            ch_r   <= in_ch;
            rrow_r <= in_read_row;
            rcol_r <= in_read_col;
            case (in_op)
              OP_WRITE: state_r <= (in_ch < CODE_LOWEST) ? ST_READ : ST_CHECK;
              OP_CLEAR: begin
                col_r   <= '0;
                line_r  <= '0;
                top_r   <= '0;
                flag_r  <= 1'b0;
                state_r <= ST_READ;
              end
              default: state_r <= ST_READ;
            endcase
          end
        end

        ST_CHECK: begin
          if (col_wrap) begin
            col_r         <= '0;
            mod_req_r.go  <= 1'b1;
            mod_req_r.val <= RCNT_W'(line_p1);
            mod_to_top_r  <= 1'b0;
            ret_r         <= ST_WRAP_TOP;
            state_r       <= ST_MOD_WAIT;
          end else begin
            state_r <= ST_CHAR;
          end
        end

        ST_WRAP_TOP: begin
          if (top_move) begin
            mod_req_r.go  <= 1'b1;
            mod_req_r.val <= RCNT_W'(top_p1);
            mod_to_top_r  <= 1'b1;
            ret_r         <= ST_CHAR;
            state_r       <= ST_MOD_WAIT;
          end else begin
            state_r <= ST_CHAR;
          end
        end

        ST_CHAR: begin
          case (ch_r)
            CODE_NL: begin
              ram_wr_r.en   <= 1'b1;
              ram_wr_r.addr <= cur_addr;
              ram_wr_r.data <= ch_r;
              col_r         <= '0;
              // top is reduced mod rows even when it does not step
              if (line_p1_wraps) begin
                line_r        <= '0;
                mod_req_r.val <= RCNT_W'(top_p1);
              end else begin
                line_r        <= ROW_W'(line_p1);
                mod_req_r.val <= flag_r ? RCNT_W'(top_p1) : RCNT_W'(top_r);
              end
              mod_req_r.go <= 1'b1;
              mod_to_top_r <= 1'b1;
              ret_r        <= ST_FINISH;
              state_r      <= ST_MOD_WAIT;
            end
            CODE_BS: begin
              if (col_r == '0) begin
                if ((line_r == '0) && flag_r) begin
                  col_r         <= last_col;
                  line_r        <= last_row;
                  ram_wr_r.en   <= 1'b1;
                  ram_wr_r.addr <= cell_addr(last_row, last_col[COLI_W-1:0]);
                  ram_wr_r.data <= CODE_SPACE;
                end else if (line_r != '0) begin
                  col_r         <= last_col;
                  line_r        <= line_r - ROW_W'(1);
                  ram_wr_r.en   <= 1'b1;
                  ram_wr_r.addr <= cell_addr(line_r - ROW_W'(1), last_col[COLI_W-1:0]);
                  ram_wr_r.data <= CODE_SPACE;
                end
              end else begin
                col_r         <= col_r - COL_W'(1);
                ram_wr_r.en   <= 1'b1;
                ram_wr_r.addr <= cell_addr(line_r, COLI_W'(col_r - COL_W'(1)));
                ram_wr_r.data <= CODE_SPACE;
              end
              state_r <= ST_FINISH;
            end
            CODE_TAB: begin
              tab_cnt_r <= '0;
              state_r   <= ST_TAB;
            end
            default: begin
              ram_wr_r.en   <= 1'b1;
              ram_wr_r.addr <= cur_addr;
              ram_wr_r.data <= ch_r;
              col_r         <= col_r + COL_W'(1);
              state_r       <= ST_FINISH;
            end
          endcase
        end

        ST_TAB: begin
          if (col_wrap) begin
            col_r <= '0;
            if (line_p1_wraps) begin
              line_r        <= '0;
              mod_req_r.val <= RCNT_W'(top_p1);
            end else begin
              line_r        <= ROW_W'(line_p1);
              mod_req_r.val <= ((top_r != '0) || flag_r) ? RCNT_W'(top_p1)
                                                         : RCNT_W'(top_r);
            end
            mod_req_r.go <= 1'b1;
            mod_to_top_r <= 1'b1;
            ret_r        <= ST_TAB_PUT;
            state_r      <= ST_MOD_WAIT;
          end else begin
            state_r <= ST_TAB_PUT;
          end
        end

        ST_TAB_PUT: begin
          ram_wr_r.en   <= 1'b1;
          ram_wr_r.addr <= cur_addr;
          ram_wr_r.data <= CODE_SPACE;
          col_r         <= col_r + COL_W'(1);
          tab_cnt_r     <= tab_cnt_r + TAB_CNT_W'(1);
          state_r       <= (tab_cnt_r == TAB_CNT_W'(TAB_SPACES - 1)) ? ST_FINISH : ST_TAB;
        end

        ST_MOD_WAIT: begin
          if (mod_rsp.done) begin
            if (mod_to_top_r) begin
              top_r <= mod_rsp.res;
            end else begin
              line_r <= mod_rsp.res;
            end
            state_r <= ret_r;
          end
        end

        ST_FINISH: begin
          if (top_r != '0) begin
            flag_r <= 1'b1;
          end
          state_r <= ST_READ;
        end

        // store write lands before this cycle; read data registers at its end
        ST_READ: state_r <= ST_RDATA;

        ST_RDATA: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_col_r   <= OUT_COL_W'(col_r);
            out_row_r   <= OUT_ROW_W'(line_r);
            out_top_r   <= OUT_ROW_W'(top_r);
            out_scr_r   <= flag_r;
            out_cell_r  <= rd_oob ? '0 : rdata;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_top_row    = out_top_r;
  assign out_scrolling  = out_scr_r;
  assign out_cell_char  = out_cell_r;

  `TCLR_ASSERT_IMP(a_clr_blocks_input, clr_busy_r, in_stall, "input open during store clear")
  `TCLR_ASSERT_NXT(a_accept_goes_busy, in_valid && !in_stall, in_stall, "idle after accept")
  `TCLR_ASSERT_IMP(a_col_range, 1'b1, 32'(col_r) <= MAX_COLS, "cursor column out of range")
  `TCLR_ASSERT_IMP(a_top_sets_flag, (state_r == ST_IDLE) && (top_r != '0), flag_r,
                   "top row moved but scroll flag clear")
  `TCLR_ASSERT_IMP(a_mod_done_waited, mod_rsp.done, state_r == ST_MOD_WAIT,
                   "modulo result with no waiting state")

endmodule
`default_nettype wire

// File: sim/console_ring_checker.sv
`timescale 1ns / 1ps
module console_ring_checker
  import tclr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CHAR_W-1:0]    in_ch,
  input  logic [IN_ROW_W-1:0]  in_read_row,
  input  logic [IN_COL_W-1:0]  in_read_col,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_COL_W-1:0] out_cursor_col,
  input  logic [OUT_ROW_W-1:0] out_cursor_row,
  input  logic [OUT_ROW_W-1:0] out_top_row,
  input  logic                 out_scrolling,
  input  logic [CHAR_W-1:0]    out_cell_char,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_ROW_W-1:0] top;
    logic                 scrolling;
    logic [CHAR_W-1:0]    glyph;
  } console_view_t;

  console_view_t     pending_views[$];
  logic [CHAR_W-1:0] screen_mem [0:MAX_ROWS*MAX_COLS-1];
  int unsigned       cur_col;
  int unsigned       cur_line;
  int unsigned       top_line;
  bit                scroll_on;
  logic [COLS_CFG_W-1:0] cols_reg;
  logic [ROWS_CFG_W-1:0] rows_reg;

  function automatic int unsigned live_cols();
    if (cols_reg == '0) return 1;
    return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
  endfunction

  function automatic int unsigned live_rows();
    if (rows_reg == '0) return 1;
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
  endfunction

  function automatic logic [CHAR_W-1:0] peek(input int unsigned row, input int unsigned col);
    if (row < MAX_ROWS && col < MAX_COLS) return screen_mem[row * MAX_COLS + col];
    return '0;
  endfunction

  // writes outside the physical store are dropped
  task automatic poke(input int unsigned row, input int unsigned col,
                      input logic [CHAR_W-1:0] v);
    if (row < MAX_ROWS && col < MAX_COLS) screen_mem[row * MAX_COLS + col] = v;
  endtask

  // top row follows a wrapping cursor only once scrolling has begun
  function automatic bit top_follows(input int unsigned rows);
    int unsigned gap;
    if (!scroll_on) return 1'b0;
    gap = (cur_line > top_line) ? cur_line - top_line : top_line - cur_line;
    return gap <= 1 || (cur_line == rows - 1 && top_line == 0);
  endfunction

  task automatic type_char(input logic [CHAR_W-1:0] c);
    int unsigned cols;
    int unsigned rows;
    cols = live_cols();
    rows = live_rows();
    if (c < CODE_LOWEST) return;

    if (cur_col >= cols) begin
      cur_col  = 0;
      cur_line = (cur_line + 1) % rows;
      if (top_follows(rows)) top_line = (top_line + 1) % rows;
    end

    if (c == CODE_NL) begin
      poke(cur_line, cur_col, c);
      cur_col = 0;
      cur_line++;
      if (cur_line >= rows) begin
        cur_line = 0;
        top_line++;
      end else if (scroll_on) begin
        top_line++;
      end
      top_line = top_line % rows;
    end else if (c == CODE_BS) begin
      if (cur_col != 0) begin
        cur_col--;
        poke(cur_line, cur_col, CODE_SPACE);
      end else if (cur_line != 0) begin
        cur_line--;
        cur_col = cols - 1;
        poke(cur_line, cur_col, CODE_SPACE);
      end else if (scroll_on) begin
        // back over the ring seam to the last cell of the last row
        cur_col  = cols - 1;
        cur_line = rows - 1;
        poke(cur_line, cur_col, CODE_SPACE);
      end
    end else if (c == CODE_TAB) begin
      repeat (TAB_SPACES) begin
        if (cur_col >= cols) begin
          cur_col = 0;
          cur_line++;
          if (cur_line >= rows) begin
            cur_line = 0;
            top_line++;
          end else if (top_line != 0 || scroll_on) begin
            top_line++;
          end
          top_line = top_line % rows;
        end
        poke(cur_line, cur_col, CODE_SPACE);
        cur_col++;
      end
    end else begin
      poke(cur_line, cur_col, c);
      cur_col++;
    end

    if (top_line != 0) scroll_on = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    console_view_t seen;
    console_view_t want;
    if (!rst_n) begin
      foreach (screen_mem[i]) screen_mem[i] = '0;
      cur_col   = 0;
      cur_line  = 0;
      top_line  = 0;
      scroll_on = 1'b0;
      cols_reg  = COLS_RESET;
      rows_reg  = ROWS_RESET;
      pending_views.delete();
      mismatches = 0;
    end else begin
      // compare first: a word leaving now cannot belong to one entering now
      if (out_valid && !out_stall) begin
        seen.col       = out_cursor_col;
        seen.row       = out_cursor_row;
        seen.top       = out_top_row;
        seen.scrolling = out_scrolling;
        seen.glyph     = out_cell_char;
        if (pending_views.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word: col %0d row %0d top %0d scroll %0b char %02h",
                     $time, seen.col, seen.row, seen.top, seen.scrolling, seen.glyph);
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          if (seen.col != want.col || seen.row != want.row || seen.top != want.top ||
              seen.scrolling != want.scrolling || seen.glyph != want.glyph) begin
            if (mismatches < 10) begin
              $display("%0t: expected col %0d row %0d top %0d scroll %0b char %02h",
                       $time, want.col, want.row, want.top, want.scrolling, want.glyph);
              $display("%0t:   actual col %0d row %0d top %0d scroll %0b char %02h",
                       $time, seen.col, seen.row, seen.top, seen.scrolling, seen.glyph);
            end
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_op)
          OP_WRITE: type_char(in_ch);
          OP_CLEAR: begin
            cur_col   = 0;
            cur_line  = 0;
            top_line  = 0;
            scroll_on = 1'b0;
          end
          default: ;
        endcase
        want.col       = OUT_COL_W'(cur_col);
        want.row       = OUT_ROW_W'(cur_line);
        want.top       = OUT_ROW_W'(top_line);
        want.scrolling = scroll_on;
        want.glyph     = peek(in_read_row, in_read_col);
        pending_views.push_back(want);
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_COLS: cols_reg = cfg_wdata;
          CFG_ROWS: rows_reg = cfg_wdata[ROWS_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_views.size();
  end

endmodule

// File: sim/text_console_line_ring_top_tb.sv
`timescale 1ns / 1ps
module text_console_line_ring_top_tb;
  import tclr_pkg::*;

  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused op, acts as a read
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 20000;  // covers the store clear after reset

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op;
  logic [CHAR_W-1:0]    in_ch;
  logic [IN_ROW_W-1:0]  in_read_row;
  logic [IN_COL_W-1:0]  in_read_col;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_COL_W-1:0] out_cursor_col;
  logic [OUT_ROW_W-1:0] out_cursor_row;
  logic [OUT_ROW_W-1:0] out_top_row;
  logic                 out_scrolling;
  logic [CHAR_W-1:0]    out_cell_char;

  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;
  int unsigned idle_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_line_ring_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_ch          (in_ch),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_top_row    (out_top_row),
    .out_scrolling  (out_scrolling),
    .out_cell_char  (out_cell_char)
  );

  console_ring_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_ch          (in_ch),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_top_row    (out_top_row),
    .out_scrolling  (out_scrolling),
    .out_cell_char  (out_cell_char),
    .mismatches     (fail_count),
    .outstanding    (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure in bursts
  always begin
    @(negedge clk);
    if (rst_n && $urandom_range(99) < idle_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(10, 1)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [IN_ROW_W-1:0] rr, input logic [IN_COL_W-1:0] rc);
    in_op       <= op;
    in_ch       <= ch;
    in_read_row <= rr;
    in_read_col <= rc;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk);
    end
  endtask

  // hold off until every word is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned cols, input int unsigned rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char(input int unsigned nl_pct);
    int unsigned r;
    if ($urandom_range(99) < nl_pct) return CODE_NL;
    r = $urandom_range(99);
    if (r < 12) return CODE_BS;
    if (r < 24) return CODE_TAB;
    if (r < 30) return CHAR_W'($urandom_range(CODE_LOWEST - 1));
    if (r < 40) return CHAR_W'($urandom_range(255));
    return CHAR_W'($urandom_range(8'h7e, 8'h21));
  endfunction

  task automatic run_phase(input int unsigned cols, input int unsigned rows,
                           input int unsigned count, input int unsigned nl_pct,
                           input int unsigned clr_pct, input int unsigned gaps);
    int unsigned r;
    int unsigned vis_cols;
    int unsigned vis_rows;
    logic [OP_W-1:0]     op;
    logic [IN_ROW_W-1:0] rr;
    logic [IN_COL_W-1:0] rc;
    settle();
    set_geometry(cols, rows);
    idle_pct = gaps;
    vis_cols = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    vis_rows = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < clr_pct)           op = OP_CLEAR;
      else if (r < clr_pct + 8)  op = OP_READ;
      else if (r < clr_pct + 11) op = OP_SPARE;
      else                       op = OP_WRITE;
      // mostly look inside the visible ring, sometimes anywhere
      if ($urandom_range(4) != 0) begin
        rr = IN_ROW_W'($urandom_range(vis_rows - 1));
        rc = IN_COL_W'($urandom_range(vis_cols - 1));
      end else begin
        rr = IN_ROW_W'($urandom_range(63));
        rc = IN_COL_W'($urandom_range(127));
      end
      send_word(op, pick_char(nl_pct), rr, rc);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_COLS;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_op       = OP_WRITE;
    in_ch       = '0;
    in_read_row = '0;
    in_read_col = '0;
    out_stall   = 1'b0;
    idle_pct    = 20;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset geometry
    send_word(OP_READ,  8'h00,           6'd0,  7'd0);
    send_word(OP_WRITE, 8'h00,           6'd0,  7'd0);
    send_word(OP_WRITE, CODE_LOWEST - 1, 6'd0,  7'd0);
    send_word(OP_WRITE, CODE_LOWEST,     6'd0,  7'd0);
    send_word(OP_WRITE, 8'hFF,           6'd0,  7'd1);
    send_word(OP_WRITE, 8'h41,           6'd0,  7'd2);
    send_word(OP_WRITE, CODE_BS,         6'd0,  7'd2);
    send_word(OP_WRITE, CODE_NL,         6'd0,  7'd2);
    send_word(OP_WRITE, CODE_BS,         6'd0,  7'd127);  // column 0, row 1: back a row
    send_word(OP_WRITE, 8'h5A,           6'd0,  7'd127);  // leaves a pending wrap
    send_word(OP_WRITE, 8'h71,           6'd1,  7'd0);
    send_word(OP_WRITE, CODE_TAB,        6'd1,  7'd4);
    send_word(OP_SPARE, 8'h55,           6'd1,  7'd1);
    send_word(OP_READ,  8'hAA,           6'd63, 7'd127);  // outside the store
    send_word(OP_READ,  8'h00,           6'd47, 7'd127);
    send_word(OP_CLEAR, 8'h00,           6'd0,  7'd0);
    send_word(OP_WRITE, CODE_BS,         6'd0,  7'd0);    // row 0, not scrolling
    send_word(OP_WRITE, CODE_NL,         6'd0,  7'd0);
    send_word(OP_WRITE, 8'h80,           6'd1,  7'd0);
    send_word(OP_WRITE, CODE_TAB,        6'd1,  7'd4);
    send_word(OP_CLEAR, 8'h00,           6'd0,  7'd0);

    //        cols rows  n  nl clr idle
    run_phase(4,   3,   90, 15, 3, 20);
    run_phase(1,   1,   40, 10, 3, 20);
    run_phase(0,   0,   30, 10, 3, 0);
    run_phase(128, 48, 120, 85, 0, 15);
    run_phase(7,   5,   90, 10, 2, 20);
    run_phase(255, 63,  60, 20, 2, 20);
    run_phase(4,   48, 150,  5, 0, 10);
    run_phase(32,  12,  80, 20, 2, 20);
    run_phase(64,  24,  60, 30, 2, 0);
    run_phase(2,   2,   60, 10, 3, 25);
    run_phase($urandom_range(128, 1), $urandom_range(48, 1), 80, 15, 2, 0);

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
